@@ design/toe_pkg.sv @@
// Shared types, constants and helper functions of the triangle pose orbit engine.
// Depends on nothing; imported by toe_cordic and triangle_pose_orbit_engine.
`timescale 1ns / 1ps

package toe_pkg;

  // CORDIC gain compensation, Q32
  localparam logic [31:0] KGAIN_Q32  = 32'd2608131496;
  localparam logic [31:0] HALF_TURN  = 32'h8000_0000;
  localparam logic [31:0] THIRD_TURN = 32'h5555_5555;
  localparam logic [31:0] TWO_THIRDS = 32'hAAAA_AAAA;

  typedef enum logic [2:0] {
    CMD_SHOW   = 3'd0,
    CMD_PLACE  = 3'd1,
    CMD_ROTATE = 3'd2,
    CMD_ORBIT  = 3'd3,
    CMD_LOCK   = 3'd4
  } toe_cmd_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_X,
    S_MUL_Y,
    S_ROT_GO,
    S_ROT_WAIT,
    S_ORB_END,
    S_VEC_GO,
    S_VEC_WAIT,
    S_VEC_END,
    S_VTX_MUL,
    S_OUT
  } toe_state_e;

  // request to the CORDIC unit
  typedef struct packed {
    logic start;
    logic vec;
  } toe_cordic_req_t;

  // status of the CORDIC unit
  typedef struct packed {
    logic busy;
    logic done;
  } toe_cordic_sts_t;

  // arctangent of 2^-i as a 32-bit binary angle
  function automatic logic [31:0] atan_at(input int i);
    logic [31:0] r;
    case (i)
      0:  r = 32'h20000000;
      1:  r = 32'h12E4051E;
      2:  r = 32'h09FB385B;
      3:  r = 32'h051111D4;
      4:  r = 32'h028B0D43;
      5:  r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;
      7:  r = 32'h00517C55;
      8:  r = 32'h0028BE53;
      9:  r = 32'h00145F2F;
      10: r = 32'h000A2F98;
      11: r = 32'h000517CC;
      12: r = 32'h00028BE6;
      13: r = 32'h000145F3;
      14: r = 32'h0000A2FA;
      15: r = 32'h0000517D;
      16: r = 32'h000028BE;
      17: r = 32'h0000145F;
      18: r = 32'h00000A30;
      19: r = 32'h00000518;
      20: r = 32'h0000028C;
      21: r = 32'h00000146;
      22: r = 32'h000000A3;
      23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  // Q32 value truncated toward zero to an integer
  function automatic logic signed [63:0] q32_trunc(input logic signed [63:0] v);
    logic signed [63:0] n;
    n = -v;
    return v[63] ? -(n >>> 32) : (v >>> 32);
  endfunction

  // saturate to 16 bits signed
  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    logic signed [15:0] r;
    if (v > 64'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -64'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

@@ design/triangle_pose_orbit_engine.sv @@
// Top level of the triangle pose orbit engine: sequencer, pose, multiplier, ports.
// Depends on toe_pkg and toe_cordic.
//
//  channel  | dir | fields (lowest bit first)
//  s_axis   | in  | tdata: command[2:0], point_x[17:3], point_y[32:18], angle_value[48:33]
//  m_axis   | out | tdata: vertex_x[15:0], vertex_y[31:16]; tlast: last_vertex
//  apb      | in  | radius at addresses 0 to 3
//
// Each vertex passes through the shared CORDIC unit (S_VTX_MUL, S_ROT_GO, S_ROT_WAIT, S_OUT);
// orbit first adds a rotation pass about the pivot, tidal lock a further vectoring pass.
// The input is taken only in the idle state; an unread vertex stalls the sequencer.
// Reset clears the pose and the radius.
`timescale 1ns / 1ps

module triangle_pose_orbit_engine import toe_pkg::*; #(
  parameter int CORDIC_STEPS = 16,
  parameter int ANGLE_BITS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // command[2:0], point_x[17:3], point_y[32:18], angle_value[48:33], zero pad
  input  logic [55:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // vertex_x[15:0], vertex_y[31:16]
  output logic [31:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [31:0] AMASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

  toe_state_e state_q, state_d;

  logic [13:0]        radius_q;
  logic signed [15:0] cx_q, cx_d, cy_q, cy_d;
  logic [15:0]        head_q, head_d;
  logic [2:0]         cmd_q, cmd_d;
  logic signed [14:0] px_q, px_d, py_q, py_d;
  logic [15:0]        ang_q, ang_d;
  logic [1:0]         k_q, k_d;
  logic               vtx_q, vtx_d;
  logic signed [63:0] mx_q, mx_d, my_q, my_d;
  logic               ov_q, ov_d, olast_q, olast_d;
  logic signed [15:0] ox_q, ox_d, oy_q, oy_d;

  logic signed [16:0] mul_a;
  logic signed [32:0] kq;
  logic signed [49:0] prod;

  toe_cordic_req_t    creq;
  toe_cordic_sts_t    csts;
  logic signed [63:0] cx0, cy0, cres_x, cres_y;
  logic signed [33:0] cz0, cres_z;

  logic               in_acc;
  logic [31:0]        rang, a_m, third;
  logic               flip;
  logic signed [16:0] dxv, dyv;
  logic [31:0]        zr;

  // configuration port
  assign pready = 1'b1;
  assign prdata = {18'd0, radius_q};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= '0;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      radius_q <= pwdata[13:0];
    end
  end

  // shared multiplier by the gain constant
  assign kq   = $signed({1'b0, KGAIN_Q32});
  assign prod = mul_a * kq;

  toe_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS),
    .ANGLE_BITS  (ANGLE_BITS)
  ) u_cordic (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (creq),
    .x0_i  (cx0),
    .y0_i  (cy0),
    .z0_i  (cz0),
    .sts_o (csts),
    .x_o   (cres_x),
    .y_o   (cres_y),
    .z_o   (cres_z)
  );

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;

  // sequencer and datapath control
  always_comb begin
    state_d = state_q;
    cx_d = cx_q;  cy_d = cy_q;  head_d = head_q;
    cmd_d = cmd_q; px_d = px_q; py_d = py_q; ang_d = ang_q;
    k_d = k_q;    vtx_d = vtx_q;
    mx_d = mx_q;  my_d = my_q;
    ox_d = ox_q;  oy_d = oy_q;  olast_d = olast_q;
    ov_d = ov_q && !m_axis_tready_i;
    creq = '0;
    cx0 = '0; cy0 = '0; cz0 = '0;
    mul_a = '0;
    dxv = '0; dyv = '0;
    zr = '0;
    third = '0;
    rang = '0; a_m = '0; flip = 1'b0;
    case (k_q)
      2'd1:    third = THIRD_TURN;
      2'd2:    third = TWO_THIRDS;
      default: third = '0;
    endcase
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_d = s_axis_tdata_i[2:0];
          px_d  = s_axis_tdata_i[17:3];
          py_d  = s_axis_tdata_i[32:18];
          ang_d = s_axis_tdata_i[48:33];
          k_d   = '0;
          case (s_axis_tdata_i[2:0])
            CMD_PLACE: begin
              cx_d   = {s_axis_tdata_i[17], s_axis_tdata_i[17:3]};
              cy_d   = {s_axis_tdata_i[32], s_axis_tdata_i[32:18]};
              head_d = s_axis_tdata_i[48:33];
              state_d = S_VTX_MUL;
            end
            CMD_ROTATE: begin
              head_d  = head_q + s_axis_tdata_i[48:33];
              state_d = S_VTX_MUL;
            end
            CMD_ORBIT, CMD_LOCK: state_d = S_MUL_X;
            default: state_d = S_VTX_MUL;
          endcase
        end
      end
      S_MUL_X: begin
        mul_a   = {cx_q[15], cx_q} - {{2{px_q[14]}}, px_q};
        mx_d    = {{14{prod[49]}}, prod};
        vtx_d   = 1'b0;
        state_d = S_MUL_Y;
      end
      S_MUL_Y: begin
        mul_a   = {cy_q[15], cy_q} - {{2{py_q[14]}}, py_q};
        my_d    = {{14{prod[49]}}, prod};
        state_d = S_ROT_GO;
      end
      S_VTX_MUL: begin
        mul_a   = {3'b000, radius_q};
        mx_d    = {{14{prod[49]}}, prod};
        my_d    = '0;
        vtx_d   = 1'b1;
        state_d = S_ROT_GO;
      end
      S_ROT_GO: begin
        // fold angles outside the right half plane by a half turn
        rang = vtx_q ? ({head_q, 16'd0} + third) : {ang_q, 16'd0};
        a_m  = rang & AMASK;
        flip = (a_m[31:30] == 2'b01) || (a_m[31:30] == 2'b10);
        if (flip) begin
          a_m = a_m ^ HALF_TURN;
          cx0 = -mx_q;
          cy0 = -my_q;
        end else begin
          cx0 = mx_q;
          cy0 = my_q;
        end
        cz0 = {{2{a_m[31]}}, a_m};
        creq.start = 1'b1;
        state_d = S_ROT_WAIT;
      end
      S_ROT_WAIT: begin
        if (csts.done) begin
          state_d = vtx_q ? S_OUT : S_ORB_END;
        end
      end
      S_ORB_END: begin
        cx_d = sat16({{49{px_q[14]}}, px_q} + q32_trunc(cres_x));
        cy_d = sat16({{49{py_q[14]}}, py_q} + q32_trunc(cres_y));
        state_d = (cmd_q == CMD_LOCK) ? S_VEC_GO : S_VTX_MUL;
      end
      S_VEC_GO: begin
        // atan2 of (pivot_x - x) over (pivot_y - y)
        dxv = {{2{py_q[14]}}, py_q} - {cy_q[15], cy_q};
        dyv = {{2{px_q[14]}}, px_q} - {cx_q[15], cx_q};
        if (dxv == '0 && dyv == '0) begin
          head_d  = '0;
          state_d = S_VTX_MUL;
        end else begin
          if (dxv[16]) begin
            cx0 = -{{23{dxv[16]}}, dxv, 24'd0};
            cy0 = -{{23{dyv[16]}}, dyv, 24'd0};
            cz0 = {2'b00, HALF_TURN};
          end else begin
            cx0 = {{23{dxv[16]}}, dxv, 24'd0};
            cy0 = {{23{dyv[16]}}, dyv, 24'd0};
            cz0 = '0;
          end
          creq.start = 1'b1;
          creq.vec   = 1'b1;
          state_d    = S_VEC_WAIT;
        end
      end
      S_VEC_WAIT: begin
        if (csts.done) begin
          state_d = S_VEC_END;
        end
      end
      S_VEC_END: begin
        zr      = (cres_z[31:0] & AMASK) + 32'h0000_8000;
        head_d  = zr[31:16];
        state_d = S_VTX_MUL;
      end
      S_OUT: begin
        if (!ov_q || m_axis_tready_i) begin
          ox_d    = sat16({{48{cx_q[15]}}, cx_q} + q32_trunc(cres_y));
          oy_d    = sat16({{48{cy_q[15]}}, cy_q} - q32_trunc(cres_x));
          olast_d = (k_q == 2'd2);
          ov_d    = 1'b1;
          if (k_q == 2'd2) begin
            k_d     = '0;
            state_d = S_IDLE;
          end else begin
            k_d     = k_q + 2'd1;
            state_d = S_VTX_MUL;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cx_q    <= '0;
      cy_q    <= '0;
      head_q  <= '0;
      k_q     <= '0;
      vtx_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cx_q    <= cx_d;
      cy_q    <= cy_d;
      head_q  <= head_d;
      k_q     <= k_d;
      vtx_q   <= vtx_d;
      ov_q    <= ov_d;
    end
  end

  // item and datapath words
  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    px_q    <= px_d;
    py_q    <= py_d;
    ang_q   <= ang_d;
    mx_q    <= mx_d;
    my_q    <= my_d;
    ox_q    <= ox_d;
    oy_q    <= oy_d;
    olast_q <= olast_d;
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = {oy_q, ox_q};
  assign m_axis_tlast_o  = olast_q;

  a_ready_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !csts.busy) else $error("ready while CORDIC runs");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready_o) else $error("second word taken at once");
  a_done_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    csts.done |-> (state_q == S_ROT_WAIT || state_q == S_VEC_WAIT))
    else $error("CORDIC result with no one waiting");
  a_last_third: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_OUT && (!ov_q || m_axis_tready_i) && k_q == 2'd2 |=> s_axis_tready_o)
    else $error("no return to idle after third vertex");

endmodule

@@ design/toe_cordic.sv @@
// Iterative CORDIC unit: one micro-rotation per cycle, rotation or vectoring mode.
// Depends on toe_pkg (arctangent table, request and status structs).
`timescale 1ns / 1ps

module toe_cordic import toe_pkg::*; #(
  parameter int CORDIC_STEPS = 16,
  parameter int ANGLE_BITS   = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  toe_cordic_req_t     req_i,
  input  logic signed [63:0]  x0_i,
  input  logic signed [63:0]  y0_i,
  input  logic signed [33:0]  z0_i,
  output toe_cordic_sts_t     sts_o,
  output logic signed [63:0]  x_o,
  output logic signed [63:0]  y_o,
  output logic signed [33:0]  z_o
);

  localparam int CW = $clog2(CORDIC_STEPS);
  localparam logic [CW-1:0] LAST = CW'(CORDIC_STEPS - 1);
  localparam logic [31:0] AMASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

  logic signed [63:0] x_q, x_d, y_q, y_d;
  logic signed [33:0] z_q, z_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic               busy_q, busy_d, done_q, done_d, vec_q, vec_d;

  logic signed [63:0] xs, ys;
  logic signed [33:0] at;
  logic               pos;

  // one micro-rotation
  always_comb begin
    xs  = x_q >>> cnt_q;
    ys  = y_q >>> cnt_q;
    at  = $signed({2'b00, atan_at(int'(cnt_q)) & AMASK});
    pos = vec_q ? !(y_q > 64'sd0) : !z_q[33];
  end

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    vec_d  = vec_q;
    done_d = 1'b0;
    if (req_i.start) begin
      x_d    = x0_i;
      y_d    = y0_i;
      z_d    = z0_i;
      vec_d  = req_i.vec;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (pos) begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - at;
      end else begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + at;
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath words
  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    z_q   <= z_d;
    vec_q <= vec_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q) else $error("start while busy");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("done without a run");
  a_count_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q && !$past(req_i.start) |-> cnt_q == '0 || done_q || $past(!busy_q))
    else $error("counter moved while idle");

endmodule
